>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AHS_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: name");

// next-cycle implication, disabled while reset is asserted
`define AHS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: name");

`endif

>>> rtl/ahs_pkg.sv
// types, constants, microcode and sine generator for the harmonic synthesizer
package ahs_pkg;

  localparam int HARMONICS_DEF       = 10;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_LOG2_DEF = 10;

  localparam int SAMPLE_W = 20;
  localparam int STEP_W   = 32;
  localparam int GAIN_W   = 15;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SINE_W   = 15;
  localparam int WEIGHT_W = 16;
  localparam int PART_N   = 3;

  localparam logic [STEP_W-1:0] STEP_ONE_RST   = 32'd32659647;
  localparam logic [STEP_W-1:0] STEP_TWO_RST   = 32'd24382887;
  localparam logic [STEP_W-1:0] STEP_THREE_RST = 32'd18193959;
  localparam logic [GAIN_W-1:0] GAIN_RST       = 15'd32000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_ONE,
    REG_STEP_TWO,
    REG_STEP_THREE,
    REG_GAIN
  } reg_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_TERM,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_NO_START,
    CND_NOT_LAST,
    CND_BUSY,
    CND_OUT_FULL
  } cond_e;

  localparam int UPC_W     = 4;
  localparam int UCODE_LEN = 10;

  localparam logic [UPC_W-1:0] UPC_WAIT   = 4'd0;
  localparam logic [UPC_W-1:0] UPC_TERM_A = 4'd2;
  localparam logic [UPC_W-1:0] UPC_TERM_B = 4'd4;
  localparam logic [UPC_W-1:0] UPC_TERM_C = 4'd6;
  localparam logic [UPC_W-1:0] UPC_DRAIN  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_FINISH = 4'd8;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
    logic [1:0]       part;
  } ucw_t;

  localparam ucw_t UCODE [UCODE_LEN] = '{
    '{op: OP_ACCEPT, cond: CND_NO_START, target: UPC_WAIT,   part: 2'd0},
    '{op: OP_LOAD,   cond: CND_NONE,     target: UPC_WAIT,   part: 2'd0},
    '{op: OP_TERM,   cond: CND_NOT_LAST, target: UPC_TERM_A, part: 2'd0},
    '{op: OP_LOAD,   cond: CND_NONE,     target: UPC_WAIT,   part: 2'd1},
    '{op: OP_TERM,   cond: CND_NOT_LAST, target: UPC_TERM_B, part: 2'd1},
    '{op: OP_LOAD,   cond: CND_NONE,     target: UPC_WAIT,   part: 2'd2},
    '{op: OP_TERM,   cond: CND_NOT_LAST, target: UPC_TERM_C, part: 2'd2},
    '{op: OP_NOP,    cond: CND_BUSY,     target: UPC_DRAIN,  part: 2'd0},
    '{op: OP_FINISH, cond: CND_OUT_FULL, target: UPC_FINISH, part: 2'd0},
    '{op: OP_NOP,    cond: CND_ALWAYS,   target: UPC_WAIT,   part: 2'd0}
  };

  // quarter-wave entry, q30 taylor series evaluated at elaboration
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                     input int unsigned log2);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    logic signed [63:0] s;
    logic [63:0] rounded;
    x = (64'd1686629713 * 64'(k)) >> log2;
    x2 = (x * x) >> 30;
    term = x;
    s = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      prod = (term * x2) >> 30;
      unique case (n)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        default: term = prod / 64'd210;
      endcase
      if (n % 2 == 1) begin
        s = s - $signed(term);
      end else begin
        s = s + $signed(term);
      end
    end
    if (s < 0) begin
      s = 64'sd0;
    end
    if (s > 64'sd1073741824) begin
      s = 64'sd1073741824;
    end
    rounded = ($unsigned(s) * 64'd32767 + 64'd536870912) >> 30;
    return rounded[SINE_W-1:0];
  endfunction

endpackage

>>> rtl/ahs_sine_rom.sv
// quarter-wave sine table with registered read
module ahs_sine_rom #(
  parameter int TABLE_LOG2 = ahs_pkg::SINE_TABLE_LOG2_DEF
) (
  input  logic                       clk_i,
  input  logic [TABLE_LOG2:0]        addr_i,
  output logic [ahs_pkg::SINE_W-1:0] data_o
);

  localparam int Depth = (1 << TABLE_LOG2) + 1;

  typedef logic [ahs_pkg::SINE_W-1:0] rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < Depth; k++) begin
      t[k] = ahs_pkg::quarter_sine(k, TABLE_LOG2);
    end
    return t;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [ahs_pkg::SINE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SineRom[addr_i];
  end

  assign data_o = data_q;

endmodule

>>> rtl/additive_harmonic_synth.sv
// additive harmonic synthesizer top level with microcoded sequencer
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   restart_i
//   out      from block out_valid_o / out_stall_i sample_o
//   cfg      to block   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one request runs from accept to the next accept through the single term
// datapath: one sine term per cycle for each partial and harmonic, then a
// pipeline drain, finish and return step.
// reset clears phases and the sequencer and loads the configuration registers with their defaults; no clearing pass.
// a stalled result holds the sequencer in its finish step; a new request is
// taken while the previous result still waits.
module additive_harmonic_synth #(
  parameter int HARMONICS       = ahs_pkg::HARMONICS_DEF,
  parameter int PHASE_BITS      = ahs_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_LOG2 = ahs_pkg::SINE_TABLE_LOG2_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ahs_pkg::SAMPLE_W-1:0]  sample_o,
  input  logic                                 cfg_we_i,
  input  logic [ahs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ahs_pkg::CFG_W-1:0]            cfg_data_i
);

  localparam int L     = SINE_TABLE_LOG2;
  localparam int HIdxW = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int P1W   = ahs_pkg::SINE_W + 1 + ahs_pkg::GAIN_W + 1;
  localparam int P2W   = P1W + ahs_pkg::WEIGHT_W + 1;
  localparam int AccBase = P2W + $clog2(3 * HARMONICS) + 1;
  localparam int AccW  = (AccBase > 51) ? AccBase : 51;
  localparam int ResW  = AccW - 30;

  localparam logic [L:0]       QuarterN = {1'b1, {L{1'b0}}};
  localparam logic [HIdxW-1:0] HLast    = HIdxW'(HARMONICS - 1);
  localparam logic signed [ResW-1:0] SatHi = ResW'((1 << (ahs_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [ResW-1:0] SatLo = -ResW'(1 << (ahs_pkg::SAMPLE_W - 1));
  localparam logic [AccW-1:0]  RoundBias = AccW'(1 << 29);

  typedef logic [ahs_pkg::WEIGHT_W-1:0] wtab_t [HARMONICS];

  // weights by shift and subtract
  function automatic wtab_t build_weights();
    wtab_t t;
    int unsigned num;
    int unsigned den;
    int unsigned quo;
    for (int i = 0; i < HARMONICS; i++) begin
      den = i + 1;
      num = 32768 + (den >> 1);
      quo = 0;
      for (int b = 16; b >= 0; b--) begin
        if (num >= (den << b)) begin
          num = num - (den << b);
          quo = quo | (1 << b);
        end
      end
      t[i] = ahs_pkg::WEIGHT_W'(quo);
    end
    return t;
  endfunction

  localparam wtab_t Weights = build_weights();

  logic [ahs_pkg::STEP_W-1:0]  step_q [ahs_pkg::PART_N];
  logic [ahs_pkg::GAIN_W-1:0]  gain_q;
  logic [PHASE_BITS-1:0]       phase_q [ahs_pkg::PART_N];

  logic [ahs_pkg::UPC_W-1:0]   upc_q, upc_d;
  ahs_pkg::ucw_t               ucw;
  logic                        cond_true;

  logic [PHASE_BITS-1:0]       hp_q;
  logic [HIdxW-1:0]            hidx_q;
  logic [PHASE_BITS-1:0]       phase_sel;
  logic                        h_last;

  logic [L+1:0]                upos;
  logic [L:0]                  rom_addr;
  logic [ahs_pkg::SINE_W-1:0]  rom_data;

  logic                        v1_q, v2_q, v3_q;
  logic                        neg1_q;
  logic [ahs_pkg::WEIGHT_W-1:0] w1_q, w2_q;
  logic signed [ahs_pkg::SINE_W:0] sine_s;
  logic signed [ahs_pkg::GAIN_W:0] gain_s;
  logic signed [ahs_pkg::WEIGHT_W:0] weight_s;
  logic signed [P1W-1:0]       prod1_q;
  logic signed [P2W-1:0]       prod2_q;
  logic signed [AccW-1:0]      acc_q;

  logic [AccW-1:0]             biased;
  logic signed [ResW-1:0]      res;
  logic signed [ahs_pkg::SAMPLE_W-1:0] sat;
  logic signed [ahs_pkg::SAMPLE_W-1:0] sample_q;
  logic                        out_valid_q;

  logic                        in_accept;
  logic                        out_full;
  logic                        busy;
  logic                        finish_fire;

  assign ucw         = ahs_pkg::UCODE[upc_q];
  assign in_stall_o  = (ucw.op != ahs_pkg::OP_ACCEPT);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_full    = out_valid_q && out_stall_i;
  assign busy        = v1_q || v2_q || v3_q;
  assign h_last      = (hidx_q == HLast);
  assign finish_fire = (ucw.op == ahs_pkg::OP_FINISH) && !out_full;

  always_comb begin
    unique case (ucw.part)
      2'd0:    phase_sel = phase_q[0];
      2'd1:    phase_sel = phase_q[1];
      default: phase_sel = phase_q[2];
    endcase
  end

  always_comb begin
    unique case (ucw.cond)
      ahs_pkg::CND_NONE:     cond_true = 1'b0;
      ahs_pkg::CND_ALWAYS:   cond_true = 1'b1;
      ahs_pkg::CND_NO_START: cond_true = !in_accept;
      ahs_pkg::CND_NOT_LAST: cond_true = !h_last;
      ahs_pkg::CND_BUSY:     cond_true = busy;
      ahs_pkg::CND_OUT_FULL: cond_true = out_full;
      default:               cond_true = 1'b0;
    endcase
    upc_d = cond_true ? ucw.target : upc_q + 1'b1;
  end

  // sine lookup address from the harmonic phase
  assign upos     = hp_q[PHASE_BITS-1 -: L+2];
  assign rom_addr = upos[L] ? (QuarterN - {1'b0, upos[L-1:0]}) : {1'b0, upos[L-1:0]};

  ahs_sine_rom #(
    .TABLE_LOG2(SINE_TABLE_LOG2)
  ) u_sine_rom (
    .clk_i (clk_i),
    .addr_i(rom_addr),
    .data_o(rom_data)
  );

  assign sine_s   = neg1_q ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
  assign gain_s   = $signed({1'b0, gain_q});
  assign weight_s = $signed({1'b0, w2_q});

  // round half up and saturate
  assign biased = $unsigned(acc_q) + RoundBias;
  assign res    = $signed(biased[AccW-1:30]);

  always_comb begin
    priority if (res > SatHi) begin
      sat = SatHi[ahs_pkg::SAMPLE_W-1:0];
    end else if (res < SatLo) begin
      sat = SatLo[ahs_pkg::SAMPLE_W-1:0];
    end else begin
      sat = res[ahs_pkg::SAMPLE_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q[0] <= ahs_pkg::STEP_ONE_RST;
      step_q[1] <= ahs_pkg::STEP_TWO_RST;
      step_q[2] <= ahs_pkg::STEP_THREE_RST;
      gain_q    <= ahs_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (ahs_pkg::reg_e'(cfg_idx_i))
        ahs_pkg::REG_STEP_ONE:   step_q[0] <= cfg_data_i;
        ahs_pkg::REG_STEP_TWO:   step_q[1] <= cfg_data_i;
        ahs_pkg::REG_STEP_THREE: step_q[2] <= cfg_data_i;
        ahs_pkg::REG_GAIN:       gain_q    <= cfg_data_i[ahs_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, phases and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ahs_pkg::UPC_WAIT;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      for (int i = 0; i < ahs_pkg::PART_N; i++) begin
        phase_q[i] <= '0;
      end
    end else begin
      upc_q <= upc_d;
      v1_q  <= (ucw.op == ahs_pkg::OP_TERM);
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      if (in_accept && restart_i) begin
        for (int i = 0; i < ahs_pkg::PART_N; i++) begin
          phase_q[i] <= '0;
        end
      end
      if (finish_fire) begin
        out_valid_q <= 1'b1;
        for (int i = 0; i < ahs_pkg::PART_N; i++) begin
          phase_q[i] <= phase_q[i] + PHASE_BITS'(step_q[i]);
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // term datapath
  always_ff @(posedge clk_i) begin
    neg1_q  <= upos[L+1];
    w1_q    <= Weights[hidx_q];
    w2_q    <= w1_q;
    prod1_q <= sine_s * gain_s;
    prod2_q <= prod1_q * weight_s;
    if (in_accept) begin
      acc_q <= '0;
    end else if (v3_q) begin
      acc_q <= acc_q + AccW'(prod2_q);
    end
    if (ucw.op == ahs_pkg::OP_LOAD) begin
      hp_q   <= phase_sel;
      hidx_q <= '0;
    end else if (ucw.op == ahs_pkg::OP_TERM) begin
      hp_q   <= hp_q + phase_sel;
      hidx_q <= hidx_q + 1'b1;
    end
    if (finish_fire) begin
      sample_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

>>> rtl/ahs_checker.sv
// port-level checker for the harmonic synthesizer and its bind
`include "assert_macros.svh"

module ahs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [ahs_pkg::SAMPLE_W-1:0] sample_o
);

  `AHS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sample_o))
  `AHS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `AHS_ASSERT_IMPL(a_result_while_busy, clk_i, rst_ni, $rose(out_valid_o), in_stall_o)
  `AHS_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o)

endmodule

bind additive_harmonic_synth ahs_checker u_ahs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .sample_o   (sample_o)
);
